// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sfc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame checker package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  localparam logic [3:0] POS_HEADER   = 4'd0;
  localparam logic [3:0] POS_COMMAND  = 4'd1;
  localparam logic [3:0] POS_FINE_LO  = 4'd2;
  localparam logic [3:0] POS_FINE_HI  = 4'd3;
  localparam logic [3:0] POS_COARSE_LO = 4'd4;
  localparam logic [3:0] POS_COARSE_HI = 4'd5;
  localparam logic [3:0] POS_CHECK    = 4'd8;
  localparam logic [3:0] POS_TAIL     = 4'd9;

  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_COMMAND = 2'd1;
  localparam logic [1:0] REG_TAIL    = 2'd2;

  localparam logic [7:0] HEADER_RESET  = 8'hAA;
  localparam logic [7:0] COMMAND_RESET = 8'hC0;
  localparam logic [7:0] TAIL_RESET    = 8'hAB;

  typedef enum logic [2:0] {
    K_HEADER,
    K_COMMAND,
    K_DATA,
    K_CHECK,
    K_TAIL,
    K_ABORT
  } kind_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] command;
    logic [7:0] tail;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] pos;
    logic [7:0] data;
    logic       match;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/sensor_frame_checker.sv
// ----------------------------------------------------------------------------
// Sensor frame checker
// Groups received bytes into 10-byte frames, checks marks and checksum, and
// reports one pass flag and two readings per frame or per abort.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_ready is high, with no
// gaps required. A byte is classified and compared against the header, command
// and tail registers in the cycle it is accepted, then passes through a short
// queue to the back end, which keeps the checksum and readings and registers
// the result. The queue and the output register let the input keep flowing
// while a result waits to be taken, until the queue fills. An abort transaction
// drops any partial frame and returns a failed result with zero readings.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// and take effect on the next accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_checker import sfc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        abort,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [15:0]      fine_reading,
  output logic [15:0]      coarse_reading
);

  cfg_t   cfg;
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header  <= HEADER_RESET;
      cfg.command <= COMMAND_RESET;
      cfg.tail    <= TAIL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEADER:  cfg.header  <= cfg_data;
        REG_COMMAND: cfg.command <= cfg_data;
        REG_TAIL:    cfg.tail    <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  sfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .abort    (abort),
    .cfg      (cfg),
    .q_valid  (push_valid),
    .q_ready  (push_ready),
    .q_entry  (push_entry)
  );

  sfc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  sfc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (pop_valid),
    .q_ready        (pop_ready),
    .q_entry        (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_ok       (frame_ok),
    .fine_reading   (fine_reading),
    .coarse_reading (coarse_reading)
  );

endmodule

`default_nettype wire

// File: sv/sfc_fifo.sv
// ----------------------------------------------------------------------------
// Sensor frame checker queue
// Short register queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfc_fifo import sfc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_entry,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output entry_t      pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count above depth")
  `ASSERT_NEXT(a_pop_drains, pop && !push && count == CNT_W'(1), !pop_valid, "queue not empty after last pop")

endmodule

`default_nettype wire

// File: sv/sfc_front.sv
// ----------------------------------------------------------------------------
// Sensor frame checker front end
// Accepts bytes, tracks the frame position and compares the configured marks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfc_front import sfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       abort,
  input  wire cfg_t       cfg,
  output logic            q_valid,
  input  wire logic       q_ready,
  output entry_t          q_entry
);

  logic [3:0] position;
  logic [3:0] position_next;
  logic [3:0] cur_pos;
  logic       accept;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;
  assign cur_pos  = (position > POS_TAIL) ? POS_HEADER : position;

  always_comb begin
    q_entry.pos   = cur_pos;
    q_entry.data  = rx_byte;
    q_entry.match = 1'b0;
    q_entry.kind  = K_DATA;
    if (abort) begin
      q_entry.kind = K_ABORT;
    end else begin
      case (cur_pos)
        POS_HEADER: begin
          q_entry.kind  = K_HEADER;
          q_entry.match = (rx_byte == cfg.header);
        end
        POS_COMMAND: begin
          q_entry.kind  = K_COMMAND;
          q_entry.match = (rx_byte == cfg.command);
        end
        POS_CHECK: begin
          q_entry.kind = K_CHECK;
        end
        POS_TAIL: begin
          q_entry.kind  = K_TAIL;
          q_entry.match = (rx_byte == cfg.tail);
        end
        default: begin
          q_entry.kind = K_DATA;
        end
      endcase
    end
  end

  always_comb begin
    position_next = position;
    if (accept) begin
      if (abort || cur_pos == POS_TAIL) begin
        position_next = POS_HEADER;
      end else begin
        position_next = cur_pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_HEADER;
    end else begin
      position <= position_next;
    end
  end

  `ASSERT_IMPLIES(a_pos_range, 1'b1, position <= POS_TAIL, "frame position out of range")

endmodule

`default_nettype wire

// File: sv/sfc_back.sv
// ----------------------------------------------------------------------------
// Sensor frame checker back end
// Accumulates checksum and readings, registers one result per frame or abort.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfc_back import sfc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire entry_t q_entry,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        frame_ok,
  output logic [15:0] fine_reading,
  output logic [15:0] coarse_reading
);

  logic [7:0]  running_sum;
  logic        marks_good;
  logic [15:0] fine_capture;
  logic [15:0] coarse_capture;
  logic        pop;
  logic        tail_ok;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;
  assign tail_ok = marks_good && q_entry.match;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      marks_good  <= 1'b1;
    end else if (pop) begin
      case (q_entry.kind)
        K_HEADER, K_COMMAND: begin
          marks_good <= marks_good && q_entry.match;
        end
        K_DATA: begin
          running_sum <= running_sum + q_entry.data;
        end
        K_CHECK: begin
          marks_good <= marks_good && (q_entry.data == running_sum);
        end
        K_TAIL, K_ABORT: begin
          running_sum <= '0;
          marks_good  <= 1'b1;
        end
        default: begin
          marks_good <= marks_good;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.kind == K_DATA) begin
      case (q_entry.pos)
        POS_FINE_LO:   fine_capture[7:0]    <= q_entry.data;
        POS_FINE_HI:   fine_capture[15:8]   <= q_entry.data;
        POS_COARSE_LO: coarse_capture[7:0]  <= q_entry.data;
        POS_COARSE_HI: coarse_capture[15:8] <= q_entry.data;
        default: begin
          fine_capture <= fine_capture;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && (q_entry.kind == K_TAIL || q_entry.kind == K_ABORT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.kind == K_TAIL) begin
      frame_ok       <= tail_ok;
      fine_reading   <= tail_ok ? fine_capture : 16'd0;
      coarse_reading <= tail_ok ? coarse_capture : 16'd0;
    end else if (pop && q_entry.kind == K_ABORT) begin
      frame_ok       <= 1'b0;
      fine_reading   <= 16'd0;
      coarse_reading <= 16'd0;
    end
  end

  `ASSERT_NEXT(a_abort_fails, pop && q_entry.kind == K_ABORT, out_valid && !frame_ok, "abort did not give a failed result")
  `ASSERT_IMPLIES(a_fail_zero, out_valid && !frame_ok, fine_reading == 16'd0 && coarse_reading == 16'd0, "failed result carries readings")

endmodule

`default_nettype wire
